[src/bole_pkg.sv]
`timescale 1ns / 1ps

package bole_pkg;

   // Fixed field widths of the stream beats
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned STATUS_W = 2;

   // Operation codes carried on the request tuser
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_BACK  = 3'd0,
      KIND_PUSH_FRONT = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_DELETE     = 3'd4,
      KIND_SEARCH     = 3'd5
   } kind_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_FULL      = 2'd1,
      STS_EMPTY     = 2'd2,
      STS_NOT_FOUND = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_SHIFT,
      S_RESULT
   } state_type;

   // Datapath operations for one cycle
   typedef enum logic [3:0] {
      DP_NOP,
      DP_PUSH_BACK,
      DP_PUSH_FRONT,
      DP_POP_FRONT,
      DP_POP_BACK,
      DP_SCAN_START,
      DP_SCAN,
      DP_SHIFT,
      DP_DEL_DONE
   } dp_op_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;
      dp_op_type  op;
      logic       set_status;
      status_type status;
      logic       load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     empty;
      logic     full;
      logic     pend;
      logic     hit;
      logic     more;
      logic     out_free;
   } sts_type;

endpackage

[src/bole_ctrl.sv]
`timescale 1ns / 1ps

module bole_ctrl import bole_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd.capture    = 1'b0;
      cmd.op         = DP_NOP;
      cmd.set_status = 1'b0;
      cmd.status     = STS_OK;
      cmd.load_out   = 1'b0;
      req_tready     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end

         S_EXEC: begin
            cmd.set_status = 1'b1;
            state_in       = S_RESULT;
            case (sts.kind)
               KIND_PUSH_BACK: begin
                  if (sts.full) begin
                     cmd.status = STS_FULL;
                  end else begin
                     cmd.op = DP_PUSH_BACK;
                  end
               end
               KIND_PUSH_FRONT: begin
                  if (sts.full) begin
                     cmd.status = STS_FULL;
                  end else begin
                     cmd.op = DP_PUSH_FRONT;
                  end
               end
               KIND_POP_FRONT: begin
                  if (sts.empty) begin
                     cmd.status = STS_EMPTY;
                  end else begin
                     cmd.op = DP_POP_FRONT;
                  end
               end
               KIND_POP_BACK: begin
                  if (sts.empty) begin
                     cmd.status = STS_EMPTY;
                  end else begin
                     cmd.op = DP_POP_BACK;
                  end
               end
               KIND_DELETE: begin
                  if (sts.empty) begin
                     cmd.status = STS_EMPTY;
                  end else begin
                     cmd.set_status = 1'b0;
                     cmd.op         = DP_SCAN_START;
                     state_in       = S_SCAN;
                  end
               end
               KIND_SEARCH: begin
                  if (sts.empty) begin
                     cmd.status = STS_NOT_FOUND;
                  end else begin
                     cmd.set_status = 1'b0;
                     cmd.op         = DP_SCAN_START;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
                  // unused codes leave the list alone
                  cmd.status = STS_OK;
               end
            endcase
         end

         S_SCAN: begin
            // read one entry per cycle, compare the one read before
            cmd.op = DP_SCAN;
            if (sts.hit) begin
               if (sts.kind == KIND_SEARCH) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = STS_OK;
                  state_in       = S_RESULT;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (sts.pend && !sts.more) begin
               cmd.set_status = 1'b1;
               cmd.status     = STS_NOT_FOUND;
               state_in       = S_RESULT;
            end
         end

         S_SHIFT: begin
            // close the gap, then drop the last place
            if (sts.pend) begin
               cmd.op = DP_SHIFT;
            end else begin
               cmd.op         = DP_DEL_DONE;
               cmd.set_status = 1'b1;
               cmd.status     = STS_OK;
               state_in       = S_RESULT;
            end
         end

         S_RESULT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[src/bole_dp.sv]
`timescale 1ns / 1ps

module bole_dp import bole_pkg::*; #(
   parameter  int unsigned CAP = 16,
   localparam int unsigned AW  = $clog2(CAP),
   localparam int unsigned CW  = $clog2(CAP + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [KIND_W-1:0]  req_kind,
   input  cmd_type            cmd,
   output sts_type            sts,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output status_type         rsp_status,
   output logic [CW-1:0]      rsp_count
);

   localparam logic [AW-1:0] LAST_SLOT = AW'(CAP - 1);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAP);
   localparam logic [CW:0]   CAP_WIDE  = (CW + 1)'(CAP);

   // Entry memory, one write and one registered read per cycle
   logic [VALUE_W-1:0] entries_ff [CAP];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               wr_en;

   kind_type           kind_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [CW-1:0]      wptr_ff, wptr_in;
   logic               cmp_vld_ff, cmp_vld_in;
   status_type         status_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [CW-1:0]      rsp_count_ff;
   logic [AW-1:0]      head_dec;
   logic               more;

   // Map a list offset to a memory slot
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW + 1)'(head) + (CW + 1)'(off);
      if (sum >= CAP_WIDE) begin
         sum = sum - CAP_WIDE;
      end
      return AW'(sum);
   endfunction

   assign more     = (ptr_ff < count_ff);
   assign head_dec = (head_ff == '0) ? LAST_SLOT : head_ff - AW'(1);

   // Status towards the controller
   assign sts.kind     = kind_ff;
   assign sts.empty    = (count_ff == '0);
   assign sts.full     = (count_ff == CAP_COUNT);
   assign sts.pend     = cmp_vld_ff;
   assign sts.hit      = cmp_vld_ff && (rd_data_ff == value_ff);
   assign sts.more     = more;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   // Next values of list state and memory port controls
   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      wptr_in    = wptr_ff;
      cmp_vld_in = cmp_vld_ff;
      wr_en      = 1'b0;
      wr_addr    = slot_of(head_ff, wptr_ff);
      wr_data    = rd_data_ff;
      rd_addr    = slot_of(head_ff, ptr_ff);

      case (cmd.op)
         DP_PUSH_BACK: begin
            wr_en    = 1'b1;
            wr_addr  = slot_of(head_ff, count_ff);
            wr_data  = value_ff;
            count_in = count_ff + CW'(1);
         end
         DP_PUSH_FRONT: begin
            wr_en    = 1'b1;
            wr_addr  = head_dec;
            wr_data  = value_ff;
            head_in  = head_dec;
            count_in = count_ff + CW'(1);
         end
         DP_POP_FRONT: begin
            head_in  = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
            count_in = count_ff - CW'(1);
         end
         DP_POP_BACK: begin
            count_in = count_ff - CW'(1);
         end
         DP_SCAN_START: begin
            ptr_in     = '0;
            cmp_vld_in = 1'b0;
         end
         DP_SCAN: begin
            // track the offset of the entry under compare
            wptr_in    = ptr_ff - CW'(1);
            cmp_vld_in = more;
            if (more) begin
               ptr_in = ptr_ff + CW'(1);
            end
         end
         DP_SHIFT: begin
            // move each later entry one place forward
            if (cmp_vld_ff) begin
               wr_en   = 1'b1;
               wptr_in = wptr_ff + CW'(1);
            end
            cmp_vld_in = more;
            if (more) begin
               ptr_in = ptr_ff + CW'(1);
            end
         end
         DP_DEL_DONE: begin
            count_in = count_ff - CW'(1);
         end
         default: begin
         end
      endcase
   end

   // Output register next valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      wptr_ff <= wptr_in;
      if (cmd.capture) begin
         kind_ff  <= kind_type'(req_kind);
         value_ff <= req_value;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.load_out) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   // Memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   // Memory read port
   always_ff @(posedge clock) begin
      rd_data_ff <= entries_ff[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

[src/bounded_ordered_list_engine.sv]
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)             tuser
// req_      in   value[31:0]                     kind[2:0]
// rsp_      out  status[1:0], count, zero fill   -
//
// Push, pop and unused codes go through the idle, execute and result states only. A search or
// a delete also scans the list, the entry memory's single read port reading one entry per
// cycle; a delete then shifts the later entries forward.
// Reset is synchronous and empties the list; memory contents are not cleared.
// A new request is taken while a finished result waits in the output
// register; the block stalls only when a second result is ready before
// the first has been taken.

module bounded_ordered_list_engine import bole_pkg::*; #(
   parameter  int unsigned CAP = 16,
   localparam int unsigned CW  = $clog2(CAP + 1),
   localparam int unsigned RDW = ((STATUS_W + CW + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // value[31:0]
   input  logic [KIND_W-1:0]  req_tuser,   // kind[2:0]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RDW-1:0]     rsp_tdata    // status[1:0], count[CW+1:2], zero fill
);

   cmd_type       cmd;
   sts_type       sts;
   status_type    rsp_status;
   logic [CW-1:0] rsp_count;

   bole_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bole_dp #(
      .CAP (CAP)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_tdata),
      .req_kind   (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   // Pack the result beat
   assign rsp_tdata = RDW'({rsp_count, rsp_status});

endmodule

[src/bole_chk.sv]
`timescale 1ns / 1ps

module bole_chk import bole_pkg::*; #(
   parameter  int unsigned CAP = 16,
   localparam int unsigned CW  = $clog2(CAP + 1),
   localparam int unsigned RDW = ((STATUS_W + CW + 7) / 8) * 8
) (
   input logic           clock,
   input logic           reset,
   input logic           rsp_tvalid,
   input logic           rsp_tready,
   input logic [RDW-1:0] rsp_tdata
);

   status_type    st;
   logic [CW-1:0] cnt;

   assign st  = status_type'(rsp_tdata[STATUS_W-1:0]);
   assign cnt = rsp_tdata[STATUS_W+CW-1:STATUS_W];

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Count never passes the capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cnt <= CW'(CAP))
      else $error("count above capacity");

   // A full report comes only with a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == STS_FULL |-> cnt == CW'(CAP))
      else $error("full status with list not full");

   // An empty report comes only with an empty list
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == STS_EMPTY |-> cnt == '0)
      else $error("empty status with entries held");

endmodule

bind bounded_ordered_list_engine bole_chk #(
   .CAP (CAP)
) u_bole_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
